// File: design/twcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twcs_pkg
// Types, codes and sizes shared by the window congestion sender.
// ----------------------------------------------------------------------------
package twcs_pkg;

	localparam int SEQ_W      = 16;
	localparam int NSEQ_W     = SEQ_W + 1;
	localparam int WIN_W      = 8;
	localparam int TIME_W     = 16;
	localparam int RING_DEPTH = 512;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [WIN_W-1:0] MAX_WINDOW = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;

	typedef enum logic [1:0] {
		FUNC_BEGIN = 2'd0,
		FUNC_SEND  = 2'd1,
		FUNC_ACK   = 2'd2,
		FUNC_TICK  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ACK_CHK,
		ST_SLIDE_RD,
		ST_SLIDE_CHK,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic ack_mark;
		logic slide_rd;
		logic slide_step;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		func_t func;
		logic  ack_in_range;
		logic  slide_ok;
		logic  mark_set;
	} sts_t;

endpackage
`default_nettype wire

// File: design/twcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twcs_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module twcs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: design/twcs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twcs_ctrl
// Sequencer: decode one item, run the ack slide loop, strobe the result.
// ----------------------------------------------------------------------------
module twcs_ctrl
	import twcs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire sts_t sts,
	output logic      busy,
	output cmd_t      cmd
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_n = ST_DECODE;
			end
			ST_DECODE: begin
				if (sts.func == FUNC_ACK && sts.ack_in_range) state_n = ST_ACK_CHK;
				else state_n = ST_FINISH;
			end
			ST_ACK_CHK: begin
				state_n = ST_SLIDE_RD;
			end
			ST_SLIDE_RD: begin
				if (sts.slide_ok) state_n = ST_SLIDE_CHK;
				else state_n = ST_FINISH;
			end
			ST_SLIDE_CHK: begin
				if (sts.mark_set) state_n = ST_SLIDE_RD;
				else state_n = ST_FINISH;
			end
			ST_FINISH: begin
				state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			ST_DECODE:    cmd.exec       = 1'b1;
			ST_ACK_CHK:   cmd.ack_mark   = 1'b1;
			ST_SLIDE_RD:  cmd.slide_rd   = 1'b1;
			ST_SLIDE_CHK: cmd.slide_step = 1'b1;
			ST_FINISH:    cmd.finish     = 1'b1;
			default:      busy           = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

// File: design/twcs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twcs_dp
// Window state, congestion control arithmetic, config registers, mark ring.
// ----------------------------------------------------------------------------
module twcs_dp
	import twcs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	input  wire logic [1:0]            func,
	input  wire logic [SEQ_W-1:0]      ack_number,
	input  wire logic                  cfg_wr,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       done,
	output logic                       send_valid,
	output logic [SEQ_W-1:0]           send_seq,
	output logic                       is_resend,
	output logic [WIN_W-1:0]           window_size,
	output logic                       ack_new,
	output logic                       ack_duplicate,
	output logic                       timed_out,
	output logic [WIN_W-1:0]           threshold_now,
	output logic                       transfer_done
);

	// config
	logic [SEQ_W-1:0]  total_q;
	logic [WIN_W-1:0]  init_thr_q;
	logic [TIME_W-1:0] timeout_q;

	// window state
	logic [SEQ_W-1:0]  base_q;
	logic [NSEQ_W-1:0] next_q;
	logic [SEQ_W-1:0]  highest_q;
	logic [WIN_W-1:0]  cwnd_q;
	logic [WIN_W-1:0]  lin_cnt_q;
	logic [WIN_W-1:0]  thr_q;
	logic              timer_run_q;
	logic [TIME_W-1:0] elapsed_q;

	// captured item and per-item flags
	func_t             func_q;
	logic [SEQ_W-1:0]  ack_q;
	logic              send_valid_q, is_resend_q, ack_new_q, ack_dup_q, timed_out_q;
	logic [SEQ_W-1:0]  send_seq_q;
	logic              done_q;

	// mark ring
	logic               ram_wr_en, ram_wr_data, ram_rd_en, ram_rd_data;
	logic [RING_AW-1:0] ram_wr_addr, ram_rd_addr;

	// combinational helpers
	logic [NSEQ_W-1:0] base_ext, base_p1, span;
	logic              send_ok, ack_low, ack_in_range, slide_ok;
	logic [NSEQ_W-1:0] tick_e;
	logic              tick_expire, outstanding;
	logic [WIN_W-1:0]  half_win, thr_begin;
	logic [WIN_W-1:0]  cwnd_grow, cnt_grow, cnt_inc;

	assign base_ext     = {1'b0, base_q};
	assign base_p1      = base_ext + NSEQ_W'(1);
	assign span         = next_q - base_ext;
	assign send_ok      = (next_q <= {1'b0, total_q})
	                      && (span <= NSEQ_W'(cwnd_q))
	                      && (span < NSEQ_W'(RING_DEPTH));
	assign ack_low      = (ack_q <= base_q);
	assign ack_in_range = !ack_low && ({1'b0, ack_q} < next_q);
	assign slide_ok     = (base_p1 < next_q);
	assign outstanding  = slide_ok;

	assign tick_e      = {1'b0, elapsed_q} + NSEQ_W'(1);
	assign tick_expire = (tick_e > {1'b0, timeout_q});
	assign half_win    = (cwnd_q < WIN_W'(2)) ? WIN_W'(1) : (cwnd_q >> 1);
	assign thr_begin   = (init_thr_q == '0) ? WIN_W'(1) : init_thr_q;

	// slow start below threshold, one step per window of slides above it
	always_comb begin
		cnt_inc   = lin_cnt_q + WIN_W'(1);
		cwnd_grow = cwnd_q;
		cnt_grow  = lin_cnt_q;
		if (cwnd_q >= thr_q) begin
			if (cnt_inc == cwnd_q) begin
				if (cwnd_q < MAX_WINDOW) cwnd_grow = cwnd_q + WIN_W'(1);
				cnt_grow = '0;
			end else begin
				cnt_grow = cnt_inc;
			end
		end else if (cwnd_q < MAX_WINDOW) begin
			cwnd_grow = cwnd_q + WIN_W'(1);
		end
	end

	// ring access
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_data = 1'b0;
		ram_wr_addr = next_q[RING_AW-1:0];
		ram_rd_en   = 1'b0;
		ram_rd_addr = ack_q[RING_AW-1:0];
		if (cmd.exec && func_q == FUNC_SEND && send_ok) begin
			ram_wr_en = 1'b1;
		end else if (cmd.ack_mark) begin
			ram_wr_en   = 1'b1;
			ram_wr_data = 1'b1;
			ram_wr_addr = ack_q[RING_AW-1:0];
		end
		if (cmd.exec && func_q == FUNC_ACK && ack_in_range) begin
			ram_rd_en = 1'b1;
		end else if (cmd.slide_rd && slide_ok) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = base_p1[RING_AW-1:0];
		end
	end

	twcs_ram #(
		.WIDTH (1),
		.DEPTH (RING_DEPTH)
	) u_marks (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= SEQ_W'(1);
			init_thr_q <= WIN_W'(16);
			timeout_q  <= TIME_W'(100);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_TOTAL:     total_q    <= cfg_data[SEQ_W-1:0];
				REG_THRESHOLD: init_thr_q <= cfg_data[WIN_W-1:0];
				REG_TIMEOUT:   timeout_q  <= cfg_data[TIME_W-1:0];
				default:       ;
			endcase
		end
	end

	// captured item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func_t'(func);
			ack_q  <= ack_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	// window state and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			next_q       <= NSEQ_W'(1);
			highest_q    <= '0;
			cwnd_q       <= WIN_W'(1);
			lin_cnt_q    <= '0;
			thr_q        <= WIN_W'(16);
			timer_run_q  <= 1'b0;
			elapsed_q    <= '0;
			send_valid_q <= 1'b0;
			send_seq_q   <= '0;
			is_resend_q  <= 1'b0;
			ack_new_q    <= 1'b0;
			ack_dup_q    <= 1'b0;
			timed_out_q  <= 1'b0;
		end else if (cmd.capture) begin
			send_valid_q <= 1'b0;
			send_seq_q   <= '0;
			is_resend_q  <= 1'b0;
			ack_new_q    <= 1'b0;
			ack_dup_q    <= 1'b0;
			timed_out_q  <= 1'b0;
		end else if (cmd.exec) begin
			unique case (func_q)
				FUNC_BEGIN: begin
					base_q      <= '0;
					next_q      <= NSEQ_W'(1);
					highest_q   <= '0;
					cwnd_q      <= WIN_W'(1);
					lin_cnt_q   <= '0;
					thr_q       <= thr_begin;
					timer_run_q <= 1'b0;
					elapsed_q   <= '0;
				end
				FUNC_SEND: begin
					if (send_ok) begin
						send_valid_q <= 1'b1;
						send_seq_q   <= next_q[SEQ_W-1:0];
						is_resend_q  <= (next_q <= {1'b0, highest_q});
						if (next_q > {1'b0, highest_q}) highest_q <= next_q[SEQ_W-1:0];
						if (!timer_run_q) begin
							timer_run_q <= 1'b1;
							elapsed_q   <= '0;
						end
						next_q <= next_q + NSEQ_W'(1);
					end
				end
				FUNC_ACK: begin
					ack_dup_q <= ack_low;
				end
				FUNC_TICK: begin
					if (timer_run_q) begin
						elapsed_q <= tick_e[TIME_W] ? '1 : tick_e[TIME_W-1:0];
						if (tick_expire) begin
							timer_run_q <= 1'b0;
							// go back to the oldest unacked sequence
							if (outstanding) begin
								thr_q       <= half_win;
								cwnd_q      <= WIN_W'(1);
								lin_cnt_q   <= '0;
								next_q      <= base_p1;
								timed_out_q <= 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end else if (cmd.ack_mark) begin
			ack_dup_q <= ram_rd_data;
			ack_new_q <= !ram_rd_data;
		end else if (cmd.slide_step) begin
			if (ram_rd_data) begin
				base_q      <= base_p1[SEQ_W-1:0];
				cwnd_q      <= cwnd_grow;
				lin_cnt_q   <= cnt_grow;
				timer_run_q <= 1'b1;
				elapsed_q   <= '0;
			end
		end
	end

	assign sts.func         = func_q;
	assign sts.ack_in_range = ack_in_range;
	assign sts.slide_ok     = slide_ok;
	assign sts.mark_set     = ram_rd_data;

	assign done          = done_q;
	assign send_valid    = send_valid_q;
	assign send_seq      = send_seq_q;
	assign is_resend     = is_resend_q;
	assign window_size   = cwnd_q;
	assign ack_new       = ack_new_q;
	assign ack_duplicate = ack_dup_q;
	assign timed_out     = timed_out_q;
	assign threshold_now = thr_q;
	assign transfer_done = (next_q > {1'b0, total_q}) && (base_q == total_q);

endmodule
`default_nettype wire

// File: design/tcp_window_congestion_sender.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_window_congestion_sender
// Sender sliding window with slow start, congestion avoidance and
// go-back-N retransmission on timeout.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  -------   -------------------------   -----------------------------------
//  item in   start & !busy               func, ack_number
//  result    done (one-cycle strobe)     send_valid .. transfer_done
//  config    cfg_valid & cfg_ready       cfg_index, cfg_data
//
//  Begin, send, tick and out-of-range ack items run DECODE then FINISH. An
//  ack in range runs DECODE, ACK_CHK, SLIDE_RD and SLIDE_CHK per slid base
//  entry, a last SLIDE_RD (with SLIDE_CHK on an unmarked entry), FINISH;
//  the slide loop uses the registered read port of the 512-entry mark RAM.
//  A new item may be accepted in the cycle done is high.
//  Reset gives the begin state and the register defaults; the mark RAM has
//  no clearing pass, every entry is written when its sequence is sent.
//  Results cannot be stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
module tcp_window_congestion_sender
	import twcs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            func,
	input  wire logic [SEQ_W-1:0]      ack_number,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       done,
	output logic                       send_valid,
	output logic [SEQ_W-1:0]           send_seq,
	output logic                       is_resend,
	output logic [WIN_W-1:0]           window_size,
	output logic                       ack_new,
	output logic                       ack_duplicate,
	output logic                       timed_out,
	output logic [WIN_W-1:0]           threshold_now,
	output logic                       transfer_done
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	twcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	twcs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.ack_number    (ack_number),
		.cfg_wr        (cfg_valid & cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.send_valid    (send_valid),
		.send_seq      (send_seq),
		.is_resend     (is_resend),
		.window_size   (window_size),
		.ack_new       (ack_new),
		.ack_duplicate (ack_duplicate),
		.timed_out     (timed_out),
		.threshold_now (threshold_now),
		.transfer_done (transfer_done)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_window_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (window_size != '0) && (threshold_now != '0))
		else $error("window or threshold reached zero");

	a_timeout_collapse: assert property (@(posedge clk) disable iff (!arst_n)
		done && timed_out |-> (window_size == WIN_W'(1)) && !send_valid && !ack_new)
		else $error("timeout result without window collapse");

	a_ack_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(ack_new && ack_duplicate) && !(send_valid && (ack_new || ack_duplicate)))
		else $error("conflicting result flags");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the window congestion sender. A queue-fed driver
// issues begin, send, ack and tick items; the monitor runs a window model on
// every accepted item and compares each done strobe with the oldest report.
// ----------------------------------------------------------------------------
module tb_top;
	import twcs_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_BURST      = 32;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		func_t            f;
		logic [SEQ_W-1:0] ack;
	} pkt_req_t;

	typedef struct packed {
		logic             send_valid;
		logic [SEQ_W-1:0] send_seq;
		logic             is_resend;
		logic [WIN_W-1:0] window_size;
		logic             ack_new;
		logic             ack_duplicate;
		logic             timed_out;
		logic [WIN_W-1:0] threshold_now;
		logic             transfer_done;
	} sender_report_t;

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  start      = 1'b0;
	logic [1:0]            func       = 2'd0;
	logic [SEQ_W-1:0]      ack_number = '0;
	logic                  cfg_valid  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  busy;
	logic                  cfg_ready;
	logic                  done;
	logic                  send_valid;
	logic [SEQ_W-1:0]      send_seq;
	logic                  is_resend;
	logic [WIN_W-1:0]      window_size;
	logic                  ack_new;
	logic                  ack_duplicate;
	logic                  timed_out;
	logic [WIN_W-1:0]      threshold_now;
	logic                  transfer_done;

	tcp_window_congestion_sender dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.ack_number    (ack_number),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.send_valid    (send_valid),
		.send_seq      (send_seq),
		.is_resend     (is_resend),
		.window_size   (window_size),
		.ack_new       (ack_new),
		.ack_duplicate (ack_duplicate),
		.timed_out     (timed_out),
		.threshold_now (threshold_now),
		.transfer_done (transfer_done)
	);

	// window model state
	logic [SEQ_W-1:0]  win_base;
	logic [NSEQ_W-1:0] model_next;
	logic [SEQ_W-1:0]  high_sent;
	logic [WIN_W-1:0]  cwnd;
	logic [WIN_W-1:0]  lin_count;
	logic [WIN_W-1:0]  ssthresh;
	bit                seq_acked [RING_DEPTH];
	bit                timer_on;
	logic [TIME_W-1:0] elapsed;
	logic [SEQ_W-1:0]  cfg_total;
	logic [WIN_W-1:0]  cfg_thresh;
	logic [TIME_W-1:0] cfg_timeout;

	pkt_req_t       req_q[$];
	sender_report_t report_q[$];
	int             err_count   = 0;
	int             quiet_cycles = 0;
	int             idle_pct    = 0;
	int             gen_count   = 0;
	logic           item_taken  = 1'b0;
	logic           cfg_taken   = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void restart_window(input logic [WIN_W-1:0] thr);
		win_base   = '0;
		model_next = NSEQ_W'(1);
		high_sent  = '0;
		cwnd       = WIN_W'(1);
		lin_count  = '0;
		ssthresh   = (thr == '0) ? 8'd1 : thr;
		timer_on   = 1'b0;
		elapsed    = '0;
	endfunction

	// slow start below threshold, one per window's worth of slides above it
	function automatic void grow_cwnd();
		if (cwnd >= ssthresh) begin
			lin_count = lin_count + 1'b1;
			if (lin_count == cwnd) begin
				if (cwnd < MAX_WINDOW)
					cwnd = cwnd + 1'b1;
				lin_count = '0;
			end
		end else if (cwnd < MAX_WINDOW) begin
			cwnd = cwnd + 1'b1;
		end
	endfunction

	function automatic logic [RING_AW-1:0] ring_slot(input logic [NSEQ_W-1:0] s);
		return s[RING_AW-1:0];
	endfunction

	function automatic bit window_finished();
		return (model_next > {1'b0, cfg_total}) && (win_base == cfg_total);
	endfunction

	function automatic sender_report_t apply_item(input logic [1:0] fc,
			input logic [SEQ_W-1:0] ack);
		sender_report_t    r;
		int                span;
		logic [NSEQ_W-1:0] tick_sum;
		logic [WIN_W-1:0]  half;
		r = '0;
		case (func_t'(fc))
			FUNC_BEGIN: restart_window(cfg_thresh);
			FUNC_SEND: begin
				span = int'(model_next) - int'(win_base);
				if (model_next <= {1'b0, cfg_total} && span <= int'(cwnd) &&
						span < RING_DEPTH) begin
					r.send_valid = 1'b1;
					r.send_seq   = model_next[SEQ_W-1:0];
					r.is_resend  = (model_next <= {1'b0, high_sent});
					if (model_next > {1'b0, high_sent})
						high_sent = model_next[SEQ_W-1:0];
					if (!timer_on) begin
						timer_on = 1'b1;
						elapsed  = '0;
					end
					seq_acked[ring_slot(model_next)] = 1'b0;
					model_next = model_next + 1'b1;
				end
			end
			FUNC_ACK: begin
				if (ack <= win_base) begin
					r.ack_duplicate = 1'b1;
				end else if ({1'b0, ack} < model_next) begin
					if (seq_acked[ring_slot({1'b0, ack})])
						r.ack_duplicate = 1'b1;
					else
						r.ack_new = 1'b1;
					seq_acked[ring_slot({1'b0, ack})] = 1'b1;
					while (int'(win_base) + 1 < int'(model_next) &&
							seq_acked[ring_slot({1'b0, win_base} + 1'b1)]) begin
						win_base = win_base + 1'b1;
						grow_cwnd();
						timer_on = 1'b1;
						elapsed  = '0;
					end
				end
			end
			FUNC_TICK: begin
				if (timer_on) begin
					tick_sum = {1'b0, elapsed} + 1'b1;
					elapsed  = (tick_sum > 17'h0FFFF) ? '1 : tick_sum[TIME_W-1:0];
					if (tick_sum > {1'b0, cfg_timeout}) begin
						timer_on = 1'b0;
						// go back to base+1 only with packets outstanding
						if (int'(win_base) + 1 < int'(model_next)) begin
							half = cwnd >> 1;
							if (half == '0)
								half = WIN_W'(1);
							ssthresh    = half;
							cwnd        = WIN_W'(1);
							lin_count   = '0;
							model_next  = {1'b0, win_base} + 1'b1;
							r.timed_out = 1'b1;
						end
					end
				end
			end
		endcase
		r.window_size   = cwnd;
		r.threshold_now = ssthresh;
		r.transfer_done = window_finished();
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		pkt_req_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || item_taken) begin
			if (req_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				nxt = req_q.pop_front();
				start      <= 1'b1;
				func       <= nxt.f;
				ack_number <= nxt.ack;
			end else begin
				start      <= 1'b0;
				func       <= 2'($urandom);
				ack_number <= 16'($urandom);
			end
		end
	end

	// monitor: results checked before the item accepted on the same edge
	always @(posedge clk) begin
		sender_report_t want;
		if (arst_n) begin
			if (done) begin
				if (report_q.size() == 0) begin
					err_count++;
					$display("%0t: result with no item outstanding, send_seq %0h",
						$time, send_seq);
				end else begin
					want = report_q.pop_front();
					check_field("send_valid", want.send_valid, send_valid);
					check_field("send_seq", want.send_seq, send_seq);
					check_field("is_resend", want.is_resend, is_resend);
					check_field("window_size", want.window_size, window_size);
					check_field("ack_new", want.ack_new, ack_new);
					check_field("ack_duplicate", want.ack_duplicate, ack_duplicate);
					check_field("timed_out", want.timed_out, timed_out);
					check_field("threshold_now", want.threshold_now, threshold_now);
					check_field("transfer_done", want.transfer_done, transfer_done);
				end
			end
			if (start && !busy)
				report_q.push_back(apply_item(func, ack_number));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TOTAL:     cfg_total   = cfg_data;
					REG_THRESHOLD: cfg_thresh  = cfg_data[WIN_W-1:0];
					REG_TIMEOUT:   cfg_timeout = cfg_data;
					default: ;
				endcase
			end
		end
		item_taken <= arst_n && start && !busy;
		cfg_taken  <= arst_n && cfg_valid && cfg_ready;
	end

	always @(posedge clk) begin
		if (arst_n && !(done || (start && !busy) || (cfg_valid && cfg_ready)))
			quiet_cycles <= quiet_cycles + 1;
		else
			quiet_cycles <= 0;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic settle();
		@(posedge clk);
		#1;
	endtask

	task automatic drain();
		while (req_q.size() != 0 || report_q.size() != 0 || start)
			settle();
	endtask

	task automatic push(input func_t fc, input logic [SEQ_W-1:0] a);
		req_q.push_back(pkt_req_t'{fc, a});
		gen_count++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do settle(); while (!cfg_taken);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic new_setting(input logic [SEQ_W-1:0] total, input logic [WIN_W-1:0] thr,
			input logic [TIME_W-1:0] tmo, input int idle);
		drain();
		repeat (3) settle();
		write_reg(REG_TOTAL, total);
		write_reg(REG_THRESHOLD, {8'h00, thr});
		write_reg(REG_TIMEOUT, tmo);
		idle_pct = idle;
		push(FUNC_BEGIN, 16'($urandom));
	endtask

	// sends up to the window edge, then acks the outstanding span
	task automatic push_window_burst(input bit shuffle, input bit lossy);
		int room;
		int n;
		int i;
		int j;
		int t;
		int acks[$];
		room = int'(cwnd) - (int'(model_next) - int'(win_base)) + 1;
		if (room > int'(cfg_total) + 1 - int'(model_next))
			room = int'(cfg_total) + 1 - int'(model_next);
		if (room < 0)
			room = 0;
		n = (room > MAX_BURST) ? MAX_BURST : room;
		if (n > 0)
			n = $urandom_range(1, n);
		for (i = 0; i < n; i++)
			push(FUNC_SEND, 16'($urandom));
		if ($urandom_range(0, 9) == 0)
			push(FUNC_SEND, 16'($urandom));
		for (i = int'(win_base) + 1; i <= int'(model_next) - 1 + n; i++)
			acks.push_back(i);
		if (shuffle) begin
			for (i = 0; i < acks.size() / 2 + 1 && acks.size() > 1; i++) begin
				j = $urandom_range(0, acks.size() - 1);
				t = acks[0];
				acks[0] = acks[j];
				acks[j] = t;
			end
		end
		foreach (acks[k])
			if (!lossy || $urandom_range(0, 7) != 0)
				push(FUNC_ACK, 16'(acks[k]));
		if (acks.size() != 0 && $urandom_range(0, 3) == 0)
			push(FUNC_ACK, 16'(acks[$urandom_range(0, acks.size() - 1)]));
		if (n == 0 && acks.size() == 0)
			push(FUNC_TICK, 16'($urandom));
	endtask

	task automatic push_ticks();
		int n;
		n = (cfg_timeout < 12) ? int'(cfg_timeout) + 2 : 12;
		n = $urandom_range(1, n);
		repeat (n) push(FUNC_TICK, 16'($urandom));
	endtask

	task automatic push_noise();
		func_t fc;
		logic [SEQ_W-1:0] a;
		repeat ($urandom_range(1, 4)) begin
			fc = func_t'($urandom_range(0, 3));
			if (fc == FUNC_BEGIN && $urandom_range(0, 1) == 0)
				fc = FUNC_ACK;
			case ($urandom_range(0, 2))
				0: a = 16'($urandom);
				1: a = 16'(int'(win_base) + $urandom_range(0, 4));
				default: a = 16'(int'(model_next) + $urandom_range(0, 2) - 1);
			endcase
			push(fc, a);
		end
	endtask

	task automatic run_mixed(input int budget);
		int first;
		int pick;
		first = gen_count;
		while (gen_count - first < budget) begin
			drain();
			pick = $urandom_range(0, 99);
			if (window_finished() || pick < 5)
				push(FUNC_BEGIN, 16'($urandom));
			else if (pick < 60)
				push_window_burst($urandom_range(0, 1), $urandom_range(0, 1));
			else if (pick < 80)
				push_ticks();
			else
				push_noise();
		end
	endtask

	// long clean transfer: the window grows through slow start
	task automatic run_deep(input int budget);
		int first;
		first = gen_count;
		while (gen_count - first < budget) begin
			drain();
			if (window_finished())
				push(FUNC_BEGIN, 16'($urandom));
			else
				push_window_burst($urandom_range(0, 3) == 0, 1'b0);
		end
	endtask

	initial begin
		cfg_total   = 16'd1;
		cfg_thresh  = 8'd16;
		cfg_timeout = 16'd100;
		for (int i = 0; i < RING_DEPTH; i++)
			seq_acked[i] = 1'b0;
		restart_window(8'd16);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: one-packet transfer, out-of-range acks, done state
		push(FUNC_TICK, 16'h0000);
		push(FUNC_ACK, 16'h0000);
		push(FUNC_ACK, 16'h0005);
		push(FUNC_SEND, 16'h0000);
		push(FUNC_SEND, 16'hFFFF);
		push(FUNC_ACK, 16'h0001);
		push(FUNC_ACK, 16'h0001);
		push(FUNC_SEND, 16'h0000);
		drain();
		repeat (3) settle();

		// zero threshold, timeout of 1: go-back-N, resend, idle timeout
		write_reg(REG_TOTAL, 16'hFFFF);
		write_reg(REG_THRESHOLD, 16'h0000);
		write_reg(REG_TIMEOUT, 16'h0001);
		write_reg(REG_SPARE, 16'($urandom));
		push(FUNC_BEGIN, 16'h0000);
		push(FUNC_SEND, 16'h0000);
		push(FUNC_SEND, 16'h0000);
		push(FUNC_TICK, 16'h0000);
		push(FUNC_TICK, 16'h0000);
		push(FUNC_SEND, 16'h0000);
		push(FUNC_ACK, 16'h0001);
		push(FUNC_SEND, 16'h0000);
		push(FUNC_SEND, 16'h0000);
		push(FUNC_ACK, 16'h0003);
		push(FUNC_ACK, 16'h0003);
		push(FUNC_ACK, 16'h0002);
		push(FUNC_TICK, 16'h0000);
		push(FUNC_TICK, 16'h0000);
		push(FUNC_ACK, 16'hFFFF);

		new_setting(16'd700, 8'd255, 16'hFFFF, 0);
		run_deep(280);
		new_setting(16'($urandom_range(1, 40)), 8'($urandom_range(1, 8)),
			16'($urandom_range(1, 6)), 53);
		run_mixed(90);
		new_setting(16'($urandom_range(300, 2000)), 8'($urandom_range(1, 255)),
			16'($urandom_range(2, 10)), 13);
		run_mixed(90);
		new_setting(16'hFFFF, 8'd1, 16'd1, 0);
		run_mixed(60);
		new_setting(16'd1, 8'd255, 16'hFFFF, 53);
		run_mixed(30);

		drain();
		repeat (10) settle();
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
